@@ rtl/read_overlap_geometry_core_macros.svh @@
// Assertion macros for the read overlap geometry core.
// Used by the top level only; no other dependencies.
`ifndef READ_OVERLAP_GEOMETRY_CORE_MACROS_SVH
`define READ_OVERLAP_GEOMETRY_CORE_MACROS_SVH
`define ROG_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ROG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/rog_pkg.sv @@
// Package for the read overlap geometry core: payload types, constants and
// order codes. No dependencies.
`default_nettype none
package rog_pkg;
   localparam int LengthBitsDefault = 16;
   localparam int PercentScale = 100;
   localparam int DivStages = 9;

   localparam logic [1:0] ORDER_NONE = 2'd0;
   localparam logic [1:0] ORDER_SAME = 2'd1;
   localparam logic [1:0] ORDER_CROSS = 2'd2;

   typedef struct packed {
      logic        first_paired;
      logic        second_paired;
      logic [31:0] first_read_id;
      logic [31:0] second_read_id;
      logic [15:0] first_left_index;
      logic [15:0] first_right_index;
      logic [15:0] second_left_index;
      logic [15:0] second_right_index;
      logic [15:0] first_len_main;
      logic [15:0] first_len_right;
      logic [15:0] second_len_main;
      logic [15:0] second_len_right;
   } req_type;

   typedef struct packed {
      logic        overlap_valid;
      logic [31:0] lead_id;
      logic [31:0] follow_id;
      logic [15:0] front_offset;
      logic [15:0] back_offset;
      logic [1:0]  order_code;
      logic [6:0]  front_percent;
      logic [6:0]  back_percent;
      logic [15:0] front_length;
      logic [15:0] back_length;
      logic        lead_type;
      logic        follow_type;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/rog_geom.sv @@
// Geometry stages: offsets, overlap lengths, denominators and validity.
// Two register stages. Depends on rog_pkg.
`default_nettype none
module rog_geom
   import rog_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire req_type in_item,
   output logic        out_valid,
   output rsp_type     out_item,
   output logic [LENGTH_BITS-1:0] out_den1,
   output logic [LENGTH_BITS-1:0] out_den2
);
   localparam int W = LENGTH_BITS + 2;
   typedef logic signed [W-1:0] sv_type;

   // Stage one: offsets.
   logic valid1_ff;
   req_type item1_ff;
   logic a_leads_ff, back_a_ff;
   sv_type pos1_ff, pos2m_ff, pos2p_ff;
   sv_type al, ar, bl, br;
   logic a_leads_in, back_a_in;
   sv_type pos1_in, pos2m_in, pos2p_in;

   always_comb begin
      al = sv_type'({2'b00, in_item.first_left_index[LENGTH_BITS-1:0]});
      ar = sv_type'({2'b00, in_item.first_right_index[LENGTH_BITS-1:0]});
      bl = sv_type'({2'b00, in_item.second_left_index[LENGTH_BITS-1:0]});
      br = sv_type'({2'b00, in_item.second_right_index[LENGTH_BITS-1:0]});
      a_leads_in = al >= bl;
      back_a_in = ar >= br;
      pos1_in = a_leads_in ? al - bl : bl - al;
      pos2m_in = ar - br;
      pos2p_in = back_a_in ? ar - br : br - ar;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      item1_ff <= in_item;
      a_leads_ff <= a_leads_in;
      back_a_ff <= back_a_in;
      pos1_ff <= pos1_in;
      pos2m_ff <= pos2m_in;
      pos2p_ff <= pos2p_in;
   end

   // Stage two: lengths and validity.
   sv_type am, arl, bm, brl, len1, len2, pos2, den1, den2;
   logic pa, pb, ok, tlead, tfollow;
   logic [1:0] ord;
   rsp_type item_in;

   function automatic sv_type smin(sv_type x, sv_type y);
      return (x < y) ? x : y;
   endfunction

   always_comb begin
      am = sv_type'({2'b00, item1_ff.first_len_main[LENGTH_BITS-1:0]});
      arl = sv_type'({2'b00, item1_ff.first_len_right[LENGTH_BITS-1:0]});
      bm = sv_type'({2'b00, item1_ff.second_len_main[LENGTH_BITS-1:0]});
      brl = sv_type'({2'b00, item1_ff.second_len_right[LENGTH_BITS-1:0]});
      pa = item1_ff.first_paired;
      pb = item1_ff.second_paired;
      ok = 1'b1;
      len2 = '0;
      pos2 = '0;
      den2 = '0;
      ord = ORDER_NONE;
      tlead = 1'b0;
      tfollow = 1'b0;
      if (a_leads_ff) begin
         len1 = smin(am - pos1_ff, bm);
      end else begin
         len1 = smin(am, bm - pos1_ff);
      end
      den1 = smin(am, bm);
      if (!pa && !pb) begin
         if (a_leads_ff && pos1_ff > am) ok = 1'b0;
         if (!a_leads_ff && pos1_ff > bm) ok = 1'b0;
      end else if (pa && !pb) begin
         if (a_leads_ff) len1 = am - pos1_ff;
         tlead = a_leads_ff;
         tfollow = !a_leads_ff;
         den1 = am;
         pos2 = -pos2m_ff;
         len2 = smin(arl, bm - pos2);
         if (pos2 < 0) ok = 1'b0;
         den2 = arl;
      end else if (!pa && pb) begin
         if (!a_leads_ff) len1 = bm - pos1_ff;
         tlead = !a_leads_ff;
         tfollow = a_leads_ff;
         den1 = bm;
         pos2 = pos2m_ff;
         len2 = smin(brl, am - pos2);
         if (pos2 < 0) ok = 1'b0;
         den2 = brl;
      end else begin
         pos2 = pos2p_ff;
         if (back_a_ff) len2 = smin(arl - pos2, brl);
         else len2 = smin(arl, brl - pos2);
         den2 = smin(arl, brl);
         ord = (a_leads_ff == back_a_ff) ? ORDER_SAME : ORDER_CROSS;
         tlead = 1'b1;
         tfollow = 1'b1;
      end
      if ((pa || pb) && len2 <= 0) ok = 1'b0;
      if (len1 <= 0) ok = 1'b0;
      item_in = '0;
      if (ok) begin
         item_in.overlap_valid = 1'b1;
         item_in.lead_id = a_leads_ff ? item1_ff.first_read_id : item1_ff.second_read_id;
         item_in.follow_id = a_leads_ff ? item1_ff.second_read_id : item1_ff.first_read_id;
         item_in.front_offset = 16'(pos1_ff);
         item_in.back_offset = 16'(pos2);
         item_in.order_code = ord;
         item_in.front_length = 16'(len1);
         item_in.back_length = 16'(len2);
         item_in.lead_type = tlead;
         item_in.follow_type = tfollow;
      end
   end

   logic [LENGTH_BITS-1:0] den1_in, den2_in;
   assign den1_in = (ok && den1 > 0) ? den1[LENGTH_BITS-1:0] : '0;
   assign den2_in = (ok && den2 > 0) ? den2[LENGTH_BITS-1:0] : '0;

   logic valid2_ff;
   rsp_type item2_ff;
   logic [LENGTH_BITS-1:0] den1_ff, den2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      item2_ff <= item_in;
      den1_ff <= den1_in;
      den2_ff <= den2_in;
   end

   assign out_valid = valid2_ff;
   assign out_item = item2_ff;
   assign out_den1 = den1_ff;
   assign out_den2 = den2_ff;
endmodule
`default_nettype wire

@@ rtl/rog_pct.sv @@
// Pipelined restoring divider for floor(len * 100 / den), one quotient bit a
// stage over the seven quotient bits. Depends on rog_pkg.
`default_nettype none
module rog_pct
   import rog_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic                   clock,
   input  wire logic [LENGTH_BITS-1:0] in_len,
   input  wire logic [LENGTH_BITS-1:0] in_den,
   output logic [6:0]                  out_pct
);
   localparam int NW = LENGTH_BITS + 8;
   // Stage zero: scale the length by 100 (the quotient never
   // exceeds 100 for a valid item; a zero denominator gives zero).
   logic [NW-1:0] num0_ff;
   logic [LENGTH_BITS-1:0] den0_ff;
   always_ff @(posedge clock) begin
      num0_ff <= (in_den == '0) ? '0 : NW'(in_len) * NW'(PercentScale);
      den0_ff <= in_den;
   end

   logic [NW-1:0] rem_ff [7];
   logic [6:0] q_ff [7];
   logic [LENGTH_BITS-1:0] den_ff [7];

   for (genvar i = 0; i < 7; i++) begin : g_step
      logic [NW-1:0] rem_prev;
      logic [6:0] q_prev;
      logic [LENGTH_BITS-1:0] den_prev;
      logic [NW+6:0] shifted;
      logic fits;
      if (i == 0) begin : g_first
         assign rem_prev = num0_ff;
         assign q_prev = '0;
         assign den_prev = den0_ff;
      end else begin : g_rest
         assign rem_prev = rem_ff[i-1];
         assign q_prev = q_ff[i-1];
         assign den_prev = den_ff[i-1];
      end
      assign shifted = (NW+7)'(den_prev) << (6 - i);
      assign fits = (den_prev != '0) && ((NW+7)'(rem_prev) >= shifted);
      always_ff @(posedge clock) begin
         rem_ff[i] <= fits ? NW'((NW+7)'(rem_prev) - shifted) : rem_prev;
         q_ff[i] <= q_prev | (7'(fits) << (6 - i));
         den_ff[i] <= den_prev;
      end
   end
   assign out_pct = q_ff[6];
endmodule
`default_nettype wire

@@ rtl/read_overlap_geometry_core.sv @@
// Top level of the read overlap geometry core: geometry stages followed by
// two percentage dividers. Depends on rog_pkg, rog_geom, rog_pct and macros.
//
// One candidate item is taken per clock cycle; busy is never raised. Each
// result appears on rsp_valid after passing two geometry stages, then one
// scaling stage and seven divider stages for the percentages.
// Results come out in order and must be taken as they appear.
`default_nettype none
`include "read_overlap_geometry_core_macros.svh"
module read_overlap_geometry_core
   import rog_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);
   logic g_valid;
   rsp_type g_item;
   logic [LENGTH_BITS-1:0] den1, den2;

   assign busy = 1'b0;

   rog_geom #(.LENGTH_BITS(LENGTH_BITS)) u_geom (
      .clock(clock), .reset(reset), .in_valid(start), .in_item(req_item),
      .out_valid(g_valid), .out_item(g_item), .out_den1(den1), .out_den2(den2)
   );

   logic [6:0] p1, p2;
   rog_pct #(.LENGTH_BITS(LENGTH_BITS)) u_pct1 (
      .clock(clock), .in_len(g_item.front_length[LENGTH_BITS-1:0]), .in_den(den1),
      .out_pct(p1)
   );
   rog_pct #(.LENGTH_BITS(LENGTH_BITS)) u_pct2 (
      .clock(clock), .in_len(g_item.back_length[LENGTH_BITS-1:0]), .in_den(den2),
      .out_pct(p2)
   );

   logic valid_ff [DivStages-1];
   rsp_type item_ff [DivStages-1];
   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else valid_ff[0] <= g_valid;
      item_ff[0] <= g_item;
      for (int i = 1; i < DivStages - 1; i++) begin
         if (reset) valid_ff[i] <= 1'b0;
         else valid_ff[i] <= valid_ff[i-1];
         item_ff[i] <= item_ff[i-1];
      end
   end

   always_comb begin
      rsp_item = item_ff[DivStages-2];
      rsp_item.front_percent = p1;
      rsp_item.back_percent = p2;
   end
   assign rsp_valid = valid_ff[DivStages-2];

   `ROG_ASSERT_NEXT(a_never_busy, clock, reset, 1'b1, !busy)
   `ROG_ASSERT_IMPLIES(a_invalid_zero, clock, reset, rsp_valid && !rsp_item.overlap_valid,
      rsp_item.lead_id == '0 && rsp_item.order_code == ORDER_NONE)
   `ROG_ASSERT_IMPLIES(a_pct_range, clock, reset, rsp_valid,
      rsp_item.front_percent <= 7'd100 && rsp_item.back_percent <= 7'd100)
endmodule
`default_nettype wire

@@ tb/tb_read_overlap_geometry_core.sv @@
// Testbench for read_overlap_geometry_core: drives candidate superread pairs and checks
// each overlap result against a predictor of the geometry. Depends on rog_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb_read_overlap_geometry_core;
   import rog_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   rsp_type overlap_queue[$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   int      valid_seen = 0;
   longint  cycles = 0;
   bit      unexpected_seen = 1'b0;

   read_overlap_geometry_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint min_len(longint a, longint b);
      return a < b ? a : b;
   endfunction

   function automatic logic [6:0] percent_of(longint len, longint den);
      if (den <= 0 || len <= 0) return 7'd0;
      return 7'((len * 100) / den);
   endfunction

   function automatic rsp_type predict_overlap(req_type r);
      rsp_type o;
      longint al, ar, bl, br, am, arl, bm, brl, pos1, pos2, len1, len2;
      bit a_leads, back_a, ok;
      logic [6:0] p1, p2;
      logic [1:0] ord;
      logic tl, tf;
      al = longint'(r.first_left_index); ar = longint'(r.first_right_index);
      bl = longint'(r.second_left_index); br = longint'(r.second_right_index);
      am = longint'(r.first_len_main); arl = longint'(r.first_len_right);
      bm = longint'(r.second_len_main); brl = longint'(r.second_len_right);
      ok = 1; pos2 = 0; len2 = 0; p2 = 0; ord = ORDER_NONE;
      a_leads = al >= bl;
      pos1 = a_leads ? al - bl : bl - al;
      if (!r.first_paired && !r.second_paired) begin
         if (a_leads) begin
            if (pos1 > am) ok = 0;
            len1 = min_len(am - pos1, bm);
         end else begin
            if (pos1 > bm) ok = 0;
            len1 = min_len(am, bm - pos1);
         end
         p1 = percent_of(len1, min_len(am, bm));
         tl = 0; tf = 0;
      end else if (r.first_paired && !r.second_paired) begin
         if (a_leads) begin
            len1 = am - pos1; tl = 1; tf = 0;
         end else begin
            len1 = min_len(am, bm - pos1); tl = 0; tf = 1;
         end
         p1 = percent_of(len1, am);
         pos2 = br - ar;
         len2 = min_len(arl, bm - pos2);
         if (len2 <= 0 || pos2 < 0) ok = 0;
         p2 = percent_of(len2, arl);
      end else if (!r.first_paired && r.second_paired) begin
         if (a_leads) begin
            len1 = min_len(bm, am - pos1); tl = 0; tf = 1;
         end else begin
            len1 = bm - pos1; tl = 1; tf = 0;
         end
         p1 = percent_of(len1, bm);
         pos2 = ar - br;
         len2 = min_len(brl, am - pos2);
         if (len2 <= 0 || pos2 < 0) ok = 0;
         p2 = percent_of(len2, brl);
      end else begin
         back_a = ar >= br;
         len1 = a_leads ? min_len(am - pos1, bm) : min_len(am, bm - pos1);
         if (back_a) begin
            pos2 = ar - br; len2 = min_len(arl - pos2, brl);
         end else begin
            pos2 = br - ar; len2 = min_len(arl, brl - pos2);
         end
         if (len2 <= 0) ok = 0;
         p1 = percent_of(len1, min_len(am, bm));
         p2 = percent_of(len2, min_len(arl, brl));
         ord = (a_leads == back_a) ? ORDER_SAME : ORDER_CROSS;
         tl = 1; tf = 1;
      end
      if (len1 <= 0) ok = 0;
      o = '0;
      if (!ok) return o;
      o.overlap_valid = 1'b1;
      o.lead_id = a_leads ? r.first_read_id : r.second_read_id;
      o.follow_id = a_leads ? r.second_read_id : r.first_read_id;
      o.front_offset = 16'(pos1);
      o.back_offset = 16'(pos2);
      o.order_code = ord;
      o.front_percent = p1;
      o.back_percent = p2;
      o.front_length = 16'(len1);
      o.back_length = 16'(len2);
      o.lead_type = tl;
      o.follow_type = tf;
      return o;
   endfunction

   // Results cannot be held off, so every cycle is checked.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (overlap_queue.size() == 0) begin
            unexpected_seen <= 1'b1;
            if (mismatches < 10) $display("Unexpected result %h", rsp_item);
            mismatches <= mismatches + 1;
         end else begin
            if (overlap_queue[0].overlap_valid) valid_seen <= valid_seen + 1;
            if (rsp_item !== overlap_queue[0]) begin
               if (mismatches < 10)
                  $display("Mismatch: expected %p actual %p", overlap_queue[0], rsp_item);
               mismatches <= mismatches + 1;
            end
            void'(overlap_queue.pop_front());
         end
      end
   end

   initial begin
      wait (cycles > 400000);
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_item(req_type r);
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      overlap_queue = {overlap_queue, predict_overlap(r)};
      items_sent++;
   endtask

   task automatic idle_gap(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic req_type random_item(int mode);
      req_type r;
      r.first_paired = 1'($urandom_range(0, 1));
      r.second_paired = 1'($urandom_range(0, 1));
      r.first_read_id = $urandom;
      r.second_read_id = $urandom;
      if (mode == 0) begin
         r.first_left_index = 16'($urandom); r.first_right_index = 16'($urandom);
         r.second_left_index = 16'($urandom); r.second_right_index = 16'($urandom);
         r.first_len_main = 16'($urandom); r.first_len_right = 16'($urandom);
         r.second_len_main = 16'($urandom); r.second_len_right = 16'($urandom);
      end else begin
         // Near-overlapping geometry so that most pairs give a valid overlap.
         r.first_len_main = 16'($urandom_range(1, 65535));
         r.second_len_main = 16'($urandom_range(1, 65535));
         r.first_len_right = 16'($urandom_range(1, 65535));
         r.second_len_right = 16'($urandom_range(1, 65535));
         r.first_left_index = 16'($urandom_range(0, 2000));
         r.second_left_index = 16'($urandom_range(0, 2000));
         r.first_right_index = 16'($urandom_range(0, 2000));
         r.second_right_index = 16'($urandom_range(0, 2000));
         if (mode == 2) begin
            r.first_left_index = 16'hFFFF - r.first_left_index;
            r.second_left_index = 16'hFFFF - r.second_left_index;
            r.first_right_index = 16'hFFFF - r.first_right_index;
            r.second_right_index = 16'hFFFF - r.second_right_index;
         end
      end
      return r;
   endfunction

   task automatic test_directed();
      req_type r;
      for (int c = 0; c < 4; c++) begin
         r = '0;
         r.first_paired = c[0]; r.second_paired = c[1];
         r.first_read_id = 32'hFFFF_FFFF; r.second_read_id = 32'h1;
         send_item(r);
         r.first_len_main = 16'hFFFF; r.second_len_main = 16'hFFFF;
         r.first_len_right = 16'hFFFF; r.second_len_right = 16'hFFFF;
         send_item(r);
         r.first_left_index = 16'hFFFF; r.first_right_index = 16'hFFFF;
         send_item(r);
         r.first_left_index = 16'd10; r.second_left_index = 16'd30;
         r.first_right_index = 16'd30; r.second_right_index = 16'd10;
         r.first_len_main = 16'd100; r.second_len_main = 16'd20;
         r.first_len_right = 16'd7; r.second_len_right = 16'd300;
         send_item(r);
         r.second_left_index = 16'd130;
         send_item(r);
      end
      idle_gap(1);
   endtask

   task automatic test_random();
      int burst;
      for (int i = 0; i < 1000; ) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst && i < 1000; j++, i++)
            send_item(random_item($urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2)));
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
      end
      idle_gap(1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      while (overlap_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d candidate pairs covering all four pairing cases;", items_sent);
      $display("checked %0d results, %0d of them valid overlaps.", results_seen, valid_seen);
      if (mismatches == 0 && !unexpected_seen) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
